/* src/assert_macros.svh */
// Assertion macros used by the top module of the subscription rate filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

`endif

/* src/csrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN subscription rate filter package
// Shared constants, types and the payload helper function of the filter.
// ----------------------------------------------------------------------------
package csrf_pkg;

    localparam int MAX_SUBSCRIPTIONS = 8;
    localparam int IDX_W = (MAX_SUBSCRIPTIONS > 1) ? $clog2(MAX_SUBSCRIPTIONS) : 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [3:0] DLC_MAX = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_entry;
        logic clear_all;
        logic capture;
        logic step;
        logic push;
        logic push_last;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last_entry;
        logic out_busy;
    } status_t;

    // Keeps the first dlc bytes of the payload and zeroes the rest.
    function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] dlc);
        logic [63:0] mask;
        mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (dlc > 4'(b)) begin
                mask[b*8 +: 8] = 8'hFF;
            end
        end
        return data & mask;
    endfunction

endpackage

/* src/csrf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN subscription rate filter controller
// Sequences item acceptance, the table scan and the release of frame copies.
// ----------------------------------------------------------------------------
module csrf_ctrl
    import csrf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic       s_frame_is_rtr,
    input  logic [3:0] s_frame_dlc,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_op)
                        OP_LOAD:  cmd.load_entry = 1'b1;
                        OP_CLEAR: cmd.clear_all  = 1'b1;
                        OP_FRAME: begin
                            if (!s_frame_is_rtr && s_frame_dlc != 4'd0) begin
                                cmd.capture  = 1'b1;
                                pending_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!(status.hit && pending_reg && status.out_busy)) begin
                    cmd.step     = 1'b1;
                    cmd.push     = status.hit && pending_reg;
                    pending_next = pending_reg || status.hit;
                    if (status.last_entry) begin
                        state_next = (pending_reg || status.hit) ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (!status.out_busy) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    pending_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* src/csrf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN subscription rate filter datapath
// Subscription table, frame holding registers, period check and output beat.
// ----------------------------------------------------------------------------
module csrf_datapath
    import csrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [2:0]  s_entry_index,
    input  logic [28:0] s_sub_frame_id,
    input  logic [31:0] s_sub_period_ms,
    input  logic [28:0] s_frame_id,
    input  logic [3:0]  s_frame_dlc,
    input  logic [63:0] s_frame_data,
    input  logic [31:0] s_now_ms,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [28:0] m_out_frame_id,
    output logic [3:0]  m_out_dlc,
    output logic [63:0] m_out_data,
    output logic        m_last_of_run
);

    logic [28:0] ids_reg    [MAX_SUBSCRIPTIONS];
    logic [31:0] periods_reg[MAX_SUBSCRIPTIONS];
    logic [31:0] lasts_reg  [MAX_SUBSCRIPTIONS];
    logic [MAX_SUBSCRIPTIONS-1:0] valid_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [28:0]      fid_reg;
    logic [3:0]       dlc_reg;
    logic [63:0]      data_reg;
    logic [31:0]      now_reg;

    logic        m_valid_reg;
    logic [28:0] out_id_reg;
    logic [3:0]  out_dlc_reg;
    logic [63:0] out_data_reg;
    logic        out_last_reg;

    logic [3:0]       dlc_sat;
    logic [31:0]      elapsed;
    logic [IDX_W-1:0] load_idx;
    logic             load_in_range;

    assign dlc_sat       = (s_frame_dlc > DLC_MAX) ? DLC_MAX : s_frame_dlc;
    assign elapsed       = now_reg - lasts_reg[idx_reg];
    assign load_idx      = IDX_W'(s_entry_index);
    assign load_in_range = 32'(s_entry_index) < 32'(MAX_SUBSCRIPTIONS);

    assign status.hit = valid_reg[idx_reg] && (ids_reg[idx_reg] == fid_reg) &&
                        ((periods_reg[idx_reg] == 32'd0) || (elapsed > periods_reg[idx_reg]));
    assign status.last_entry = (idx_reg == IDX_W'(MAX_SUBSCRIPTIONS - 1));
    assign status.out_busy   = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear_all) begin
            valid_reg <= '0;
        end else if (cmd.load_entry && load_in_range) begin
            valid_reg[load_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_entry && load_in_range) begin
            ids_reg[load_idx]     <= s_sub_frame_id;
            periods_reg[load_idx] <= s_sub_period_ms;
            lasts_reg[load_idx]   <= 32'd0;
        end else if (cmd.step && status.hit) begin
            lasts_reg[idx_reg] <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg  <= '0;
            fid_reg  <= s_frame_id;
            dlc_reg  <= dlc_sat;
            data_reg <= keep_bytes(s_frame_data, dlc_sat);
            now_reg  <= s_now_ms;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_id_reg   <= fid_reg;
            out_dlc_reg  <= dlc_reg;
            out_data_reg <= data_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_frame_id = out_id_reg;
    assign m_out_dlc      = out_dlc_reg;
    assign m_out_data     = out_data_reg;
    assign m_last_of_run  = out_last_reg;

endmodule

/* src/can_subscription_rate_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN subscription rate filter
// Forwards received CAN frames once per matching subscription, rate limited.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat carries
//  s_        in         load entry, received frame or clear table
//  m_        out        one forwarded frame copy, flagged on the last copy
//
// A load or clear beat is applied to the table on acceptance. A received frame
// that is not RTR and has a nonzero DLC is scanned one table slot per step
// (eight slots); if one matched, the last copy follows. No beat is taken then.
// Reset clears the valid bits of all slots and empties the output register.
// The scan halts whilst a copy must leave and the output beat is still held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module can_subscription_rate_filter
    import csrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [2:0]  s_entry_index,
    input  logic [28:0] s_sub_frame_id,
    input  logic [31:0] s_sub_period_ms,
    input  logic [28:0] s_frame_id,
    input  logic        s_frame_is_rtr,
    input  logic [3:0]  s_frame_dlc,
    input  logic [63:0] s_frame_data,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [28:0] m_out_frame_id,
    output logic [3:0]  m_out_dlc,
    output logic [63:0] m_out_data,
    output logic        m_last_of_run
);

    cmd_t    cmd;
    status_t status;

    csrf_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_frame_is_rtr (s_frame_is_rtr),
        .s_frame_dlc    (s_frame_dlc),
        .status         (status),
        .cmd            (cmd)
    );

    csrf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_entry_index   (s_entry_index),
        .s_sub_frame_id  (s_sub_frame_id),
        .s_sub_period_ms (s_sub_period_ms),
        .s_frame_id      (s_frame_id),
        .s_frame_dlc     (s_frame_dlc),
        .s_frame_data    (s_frame_data),
        .s_now_ms        (s_now_ms),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_frame_id  (m_out_frame_id),
        .m_out_dlc       (m_out_dlc),
        .m_out_data      (m_out_data),
        .m_last_of_run   (m_last_of_run)
    );

    `ASSERT_IMPLIES(a_push_no_overwrite, aclk, aresetn, cmd.push, !(m_valid && !m_ready))
    `ASSERT_IMPLIES(a_capture_on_beat, aclk, aresetn, cmd.capture, s_valid && s_ready)
    `ASSERT_ALWAYS(a_one_table_op, aclk, aresetn, $onehot0({cmd.load_entry, cmd.clear_all, cmd.capture, cmd.step}))
    `ASSERT_IMPLIES(a_no_accept_in_scan, aclk, aresetn, cmd.step, !s_ready)

endmodule

/* test/can_subscription_rate_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN subscription rate filter testbench
// Drives loads, clears and received frames into the filter in bursts with
// random gaps, whilst the output side stalls on its own pattern and once
// holds off long enough to fill the block. Every beat that is accepted is run
// through a local model of the subscription table, and each forwarded copy is
// checked field by field against the oldest copy that the model expects.
// ----------------------------------------------------------------------------
module can_subscription_rate_filter_test;
    import csrf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_COPIES = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_BEATS = 200;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  entry_index;
        logic [28:0] sub_frame_id;
        logic [31:0] sub_period_ms;
        logic [28:0] frame_id;
        logic        frame_is_rtr;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
        logic [31:0] now_ms;
    } filter_beat_t;

    typedef struct packed {
        logic [28:0] frame_id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        last;
    } frame_copy_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_EVERY_THIRD
    } rx_mode_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_LOAD;
    logic [2:0]  s_entry_index = '0;
    logic [28:0] s_sub_frame_id = '0;
    logic [31:0] s_sub_period_ms = '0;
    logic [28:0] s_frame_id = '0;
    logic        s_frame_is_rtr = 1'b0;
    logic [3:0]  s_frame_dlc = '0;
    logic [63:0] s_frame_data = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_valid;
    logic        m_ready;
    logic [28:0] m_out_frame_id;
    logic [3:0]  m_out_dlc;
    logic [63:0] m_out_data;
    logic        m_last_of_run;

    logic [28:0] sub_ids [MAX_SUBSCRIPTIONS];
    logic [31:0] sub_periods [MAX_SUBSCRIPTIONS];
    logic [31:0] sub_last_ms [MAX_SUBSCRIPTIONS];
    logic        sub_valid [MAX_SUBSCRIPTIONS];

    frame_copy_t pending_copies[$];
    frame_copy_t oldest_copy;
    int          mismatches = 0;
    int          hold_requests = 0;
    int          burst_left = 0;
    bit          gaps_enabled = 1'b1;
    logic [31:0] clock_ms = '0;

    can_subscription_rate_filter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_entry_index  (s_entry_index),
        .s_sub_frame_id (s_sub_frame_id),
        .s_sub_period_ms(s_sub_period_ms),
        .s_frame_id     (s_frame_id),
        .s_frame_is_rtr (s_frame_is_rtr),
        .s_frame_dlc    (s_frame_dlc),
        .s_frame_data   (s_frame_data),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_frame_id (m_out_frame_id),
        .m_out_dlc      (m_out_dlc),
        .m_out_data     (m_out_data),
        .m_last_of_run  (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic filter_beat_t load_beat(input logic [2:0] slot, input logic [28:0] id,
                                               input logic [31:0] period);
        filter_beat_t b;
        b = '0;
        b.op = OP_LOAD;
        b.entry_index = slot;
        b.sub_frame_id = id;
        b.sub_period_ms = period;
        return b;
    endfunction

    function automatic filter_beat_t frame_beat(input logic [28:0] id, input logic rtr,
                                                input logic [3:0] dlc, input logic [63:0] data,
                                                input logic [31:0] now);
        filter_beat_t b;
        b = '0;
        b.op = OP_FRAME;
        b.frame_id = id;
        b.frame_is_rtr = rtr;
        b.frame_dlc = dlc;
        b.frame_data = data;
        b.now_ms = now;
        return b;
    endfunction

    function automatic filter_beat_t bare_beat(input logic [1:0] op);
        filter_beat_t b;
        b = '0;
        b.op = op;
        return b;
    endfunction

    // Updates the subscription table for one accepted beat and queues the copies it forwards.
    function automatic void apply_beat(input filter_beat_t b);
        int          copies;
        int          len;
        logic [31:0] elapsed;
        logic [63:0] payload;
        frame_copy_t c;
        copies = 0;
        case (b.op)
            OP_LOAD: begin
                if (b.entry_index < MAX_SUBSCRIPTIONS) begin
                    sub_ids[b.entry_index] = b.sub_frame_id;
                    sub_periods[b.entry_index] = b.sub_period_ms;
                    sub_last_ms[b.entry_index] = '0;
                    sub_valid[b.entry_index] = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < MAX_SUBSCRIPTIONS; i++) begin
                    sub_valid[i] = 1'b0;
                end
            end
            OP_FRAME: begin
                if (!b.frame_is_rtr && b.frame_dlc != 4'd0) begin
                    len = (b.frame_dlc > DLC_MAX) ? int'(DLC_MAX) : int'(b.frame_dlc);
                    payload = (len >= 8) ? b.frame_data
                                         : b.frame_data & ((64'd1 << (8 * len)) - 64'd1);
                    for (int i = 0; i < MAX_SUBSCRIPTIONS; i++) begin
                        elapsed = b.now_ms - sub_last_ms[i];
                        if (copies < MAX_COPIES && sub_valid[i] && sub_ids[i] == b.frame_id
                                && (sub_periods[i] == '0 || elapsed > sub_periods[i])) begin
                            sub_last_ms[i] = b.now_ms;
                            copies++;
                        end
                    end
                    for (int k = 0; k < copies; k++) begin
                        c.frame_id = b.frame_id;
                        c.dlc = 4'(len);
                        c.data = payload;
                        c.last = (k == copies - 1);
                        pending_copies = {pending_copies, c};
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_beat(input filter_beat_t b);
        @(negedge aclk);
        s_valid = 1'b1;
        s_op = b.op;
        s_entry_index = b.entry_index;
        s_sub_frame_id = b.sub_frame_id;
        s_sub_period_ms = b.sub_period_ms;
        s_frame_id = b.frame_id;
        s_frame_is_rtr = b.frame_is_rtr;
        s_frame_dlc = b.frame_dlc;
        s_frame_data = b.frame_data;
        s_now_ms = b.now_ms;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        apply_beat(b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            if (gaps_enabled) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge aclk);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_copies.size() == 0) begin
                $display({"%0t: unexpected beat, expected none, ",
                          "actual id %h dlc %0d data %h last %b"},
                         $time, m_out_frame_id, m_out_dlc, m_out_data, m_last_of_run);
                mismatches++;
            end else begin
                oldest_copy = pending_copies.pop_front();
                check_field("out_frame_id", 64'(oldest_copy.frame_id), 64'(m_out_frame_id));
                check_field("out_dlc", 64'(oldest_copy.dlc), 64'(m_out_dlc));
                check_field("out_data", oldest_copy.data, m_out_data);
                check_field("last_of_run", 64'(oldest_copy.last), 64'(m_last_of_run));
            end
        end
    end

    initial begin : receiver
        int       cyc;
        int       holds_done;
        int       hold_left;
        rx_mode_t mode;
        cyc = 0;
        holds_done = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_left == 0 && holds_done != hold_requests) begin
                hold_left = LONG_HOLD_CYCLES;
                holds_done++;
            end
            mode = rx_mode_t'((cyc / 97) % 4);
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:        m_ready = 1'b1;
                    RX_HALF:        m_ready = $urandom_range(0, 1);
                    RX_SPARSE:      m_ready = ($urandom_range(0, 3) == 0);
                    RX_EVERY_THIRD: m_ready = (cyc % 3 == 0);
                    default:        m_ready = 1'b1;
                endcase
            end
        end
    end

    // Every slot subscribes to the same identifier, so one frame fans out to the full run.
    task automatic test_fan_out();
        for (int i = 0; i < MAX_SUBSCRIPTIONS; i++) begin
            send_beat(load_beat(3'(i), 29'h1FFF_FFFF, '0));
        end
        send_beat(frame_beat(29'h1FFF_FFFF, 1'b0, 4'd15, {64{1'b1}}, 32'hFFFF_FFFF));
    endtask

    task automatic test_dropped_frames();
        send_beat(frame_beat(29'h1FFF_FFFF, 1'b1, 4'd8, {$urandom, $urandom}, 32'd7));
        send_beat(frame_beat(29'h1FFF_FFFF, 1'b0, 4'd0, {$urandom, $urandom}, 32'd9));
        send_beat(bare_beat(OP_UNUSED));
    endtask

    task automatic test_rate_limit();
        send_beat(bare_beat(OP_CLEAR));
        send_beat(load_beat(3'd2, '0, 32'd100));
        send_beat(load_beat(3'd5, '0, 32'hFFFF_FFFF));
        send_beat(frame_beat('0, 1'b0, 4'd3, {$urandom, $urandom}, 32'd100));
        send_beat(frame_beat('0, 1'b0, 4'd1, {$urandom, $urandom}, 32'd101));
        send_beat(frame_beat('0, 1'b0, 4'd9, {$urandom, $urandom}, 32'd150));
        send_beat(frame_beat('0, 1'b0, 4'd5, {$urandom, $urandom}, 32'd0));
    endtask

    task automatic test_clear_and_reload();
        send_beat(bare_beat(OP_CLEAR));
        send_beat(frame_beat('0, 1'b0, 4'd8, {$urandom, $urandom}, 32'd4000));
        send_beat(load_beat(3'd3, '0, '0));
        send_beat(frame_beat('0, 1'b0, 4'd8, '0, 32'd5));
    endtask

    // The output side holds off whilst full fan-out frames keep arriving.
    task automatic test_backpressure();
        logic [28:0] id;
        id = 29'($urandom);
        gaps_enabled = 1'b0;
        send_beat(bare_beat(OP_CLEAR));
        for (int i = 0; i < MAX_SUBSCRIPTIONS; i++) begin
            send_beat(load_beat(3'(i), id, '0));
        end
        hold_requests++;
        for (int n = 0; n < 12; n++) begin
            send_beat(frame_beat(id, 1'b0, 4'($urandom_range(1, 8)), {$urandom, $urandom},
                                 32'($urandom)));
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [28:0]  id_pool [4];
        filter_beat_t b;
        int           sent;
        int           pick;
        sent = 0;
        foreach (id_pool[i]) begin
            id_pool[i] = 29'($urandom);
        end
        while (sent < RANDOM_BEATS) begin
            gaps_enabled = ((sent / 60) % 2 == 0);
            b.entry_index = 3'($urandom);
            b.sub_frame_id = ($urandom_range(0, 9) == 0) ? 29'($urandom)
                                                         : id_pool[$urandom_range(0, 3)];
            pick = $urandom_range(0, 9);
            b.sub_period_ms = (pick < 3) ? '0 : (pick < 8) ? 32'($urandom_range(1, 50))
                                                           : 32'($urandom);
            b.frame_id = ($urandom_range(0, 19) < 3) ? 29'($urandom)
                                                     : id_pool[$urandom_range(0, 3)];
            b.frame_is_rtr = ($urandom_range(0, 9) == 0);
            b.frame_dlc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 9));
            b.frame_data = {$urandom, $urandom};
            if ($urandom_range(0, 29) == 0) begin
                clock_ms = $urandom;
            end else begin
                clock_ms = clock_ms + 32'($urandom_range(0, 40));
            end
            b.now_ms = clock_ms;
            pick = $urandom_range(0, 99);
            b.op = (pick < 20) ? OP_LOAD : (pick < 24) ? OP_CLEAR
                 : (pick < 27) ? OP_UNUSED : OP_FRAME;
            send_beat(b);
            if (b.op != OP_UNUSED) begin
                sent++;
            end
        end
    endtask

    initial begin
        foreach (sub_valid[i]) begin
            sub_valid[i] = 1'b0;
            sub_last_ms[i] = '0;
            sub_ids[i] = '0;
            sub_periods[i] = '0;
        end
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_fan_out();
        test_dropped_frames();
        test_rate_limit();
        test_clear_and_reload();
        test_backpressure();
        test_random_traffic();

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_copies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
